// ===== rtl/spdr_pkg.sv =====
// ----------------------------------------------------------------------------
// spdr_pkg
// shared types and constants of the serial packet deframer and router
// ----------------------------------------------------------------------------
`default_nettype none

package spdr_pkg;

	localparam logic [7:0]  DELIM_RESET   = 8'd126;
	localparam logic [15:0] LOCAL_RESET   = 16'd1;
	localparam logic [15:0] MAXLEN_RESET  = 16'd400;
	localparam logic [15:0] MIN_ROUTED    = 16'd4;
	localparam logic [15:0] BCAST_ADDR    = 16'hffff;

	typedef enum logic [1:0] {
		CFG_DELIM  = 2'd0,
		CFG_LOCAL  = 2'd1,
		CFG_MAXLEN = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_LEN_HI = 2'd1,
		PH_LEN_LO = 2'd2,
		PH_DATA   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		V_NONE    = 3'd0,
		V_DROP    = 3'd1,
		V_LOCAL   = 3'd2,
		V_FORWARD = 3'd3,
		V_BOTH    = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [7:0]  delimiter_value;
		logic [15:0] local_address;
		logic [15:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic        last_byte;
		verdict_t    verdict;
		logic        length_error;
		logic        base_station;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/spdr_parser.sv =====
// ----------------------------------------------------------------------------
// spdr_parser
// framing state machine: delimiter hunt, length check, payload and routing
// ----------------------------------------------------------------------------
`default_nettype none

module spdr_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    rx_byte,
	input  wire spdr_pkg::cfg_t cfg,
	output logic               res_valid,
	output spdr_pkg::res_t     res
);
	import spdr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] exp_len_q, exp_len_d;
	logic [15:0] seen_q, seen_d;
	logic [15:0] dest_q, dest_d;
	logic        base_q, base_d;

	logic [15:0] len_w;
	logic [15:0] seen_inc;
	logic        last_w;
	verdict_t    route_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			exp_len_q <= '0;
			seen_q    <= '0;
			dest_q    <= '0;
			base_q    <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			exp_len_q <= exp_len_d;
			seen_q    <= seen_d;
			dest_q    <= dest_d;
			base_q    <= base_d;
		end
	end

	assign len_w    = {exp_len_q[15:8], rx_byte};
	assign seen_inc = seen_q + 16'd1;
	assign last_w   = (seen_inc == exp_len_q);

	always_comb begin
		phase_d   = phase_q;
		exp_len_d = exp_len_q;
		seen_d    = seen_q;
		dest_d    = dest_q;
		base_d    = base_q;
		res_valid = 1'b0;
		route_w   = V_NONE;
		res       = '{data_byte: 8'd0, byte_index: 16'd0, last_byte: 1'b0,
			verdict: V_NONE, length_error: 1'b0, base_station: base_q};
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == cfg.delimiter_value) begin
					phase_d = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				exp_len_d = {rx_byte, 8'd0};
				phase_d   = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (len_w == 16'd0 || len_w > cfg.max_length) begin
					exp_len_d        = '0;
					phase_d          = PH_HUNT;
					res_valid        = step;
					res.length_error = 1'b1;
				end else begin
					exp_len_d = len_w;
					seen_d    = '0;
					phase_d   = PH_DATA;
				end
			end
			PH_DATA: begin
				// first two payload bytes form the destination address
				if (seen_q == 16'd0) begin
					dest_d = {rx_byte, 8'd0};
				end else if (seen_q == 16'd1) begin
					dest_d = {dest_q[15:8], rx_byte};
				end
				seen_d = seen_inc;
				if (last_w) begin
					if (exp_len_q < MIN_ROUTED) begin
						route_w = V_DROP;
					end else if (dest_d == 16'd0 || dest_d == BCAST_ADDR) begin
						route_w = V_BOTH;
					end else if (dest_d == cfg.local_address) begin
						route_w = V_LOCAL;
					end else begin
						route_w = V_FORWARD;
					end
					if (route_w != V_DROP) begin
						base_d = 1'b1;
					end
					phase_d = PH_HUNT;
					seen_d  = '0;
				end
				res_valid        = step;
				res.data_byte    = rx_byte;
				res.byte_index   = seen_q;
				res.last_byte    = last_w;
				res.verdict      = route_w;
				res.base_station = base_d;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/spdr_result_reg.sv =====
// ----------------------------------------------------------------------------
// spdr_result_reg
// result register holding one result until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module spdr_result_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire logic           in_valid,
	input  wire spdr_pkg::res_t in_res,
	output logic                out_valid,
	output spdr_pkg::res_t      out_res
);
	import spdr_pkg::*;

	logic valid_s2;
	res_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			res_s2 <= in_res;
		end
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

endmodule

`default_nettype wire

// ===== rtl/serial_packet_deframer_router_top.sv =====
// ----------------------------------------------------------------------------
// serial_packet_deframer_router_top
// length-prefixed serial deframer with destination routing verdict
// ----------------------------------------------------------------------------
// path: a byte passes the input register and the parse step into the result
//   register, which holds its result while res_stall is high
// throughput: one byte per cycle unless res_stall holds the result register,
//   set by the single parse step; a header gives a result only on a length error
// reset: phase, counters, address and base-station flag clear, valids drop,
//   configuration returns to delimiter 126, address 1, max length 400
`default_nettype none

module serial_packet_deframer_router_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [7:0]       data_byte,
	output logic [15:0]      byte_index,
	output logic             last_byte,
	output logic [2:0]       verdict,
	output logic             length_error,
	output logic             base_station,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import spdr_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        step;
	logic        p_valid;
	res_t        p_res;
	res_t        o_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_value <= DELIM_RESET;
			cfg_q.local_address   <= LOCAL_RESET;
			cfg_q.max_length      <= MAXLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DELIM:  cfg_q.delimiter_value <= cfg_data[7:0];
				CFG_LOCAL:  cfg_q.local_address   <= cfg_data;
				CFG_MAXLEN: cfg_q.max_length      <= cfg_data;
				default: ;
			endcase
		end
	end

	// the parse step runs whenever a byte is held and the result register can take its output
	assign adv      = !res_valid || !res_stall;
	assign step     = valid_s1 && adv;
	assign rx_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	spdr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (p_valid),
		.res       (p_res)
	);

	spdr_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.in_valid  (p_valid),
		.in_res    (p_res),
		.out_valid (res_valid),
		.out_res   (o_res)
	);

	assign data_byte    = o_res.data_byte;
	assign byte_index   = o_res.byte_index;
	assign last_byte    = o_res.last_byte;
	assign verdict      = o_res.verdict;
	assign length_error = o_res.length_error;
	assign base_station = o_res.base_station;

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && length_error |->
			data_byte == 8'd0 && byte_index == 16'd0 && !last_byte && verdict == V_NONE)
		else $error("length error result carries payload fields");

	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (last_byte == (verdict != V_NONE)))
		else $error("verdict not aligned with last byte");

	a_routed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last_byte && verdict != V_DROP |-> base_station)
		else $error("routed packet without base-station flag");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && res_valid && res_stall)
		else $error("input stalled with room to advance");

endmodule

`default_nettype wire
